### rtl/pixel_unpremultiply_convert_macros.svh
// Assertion macros shared by the puc_div and puc_format files of the unpremultiply block.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef PIXEL_UNPREMULTIPLY_CONVERT_MACROS_SVH
`define PIXEL_UNPREMULTIPLY_CONVERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PUC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PUC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/puc_pkg.sv
`default_nettype none

package puc_pkg;

	// Number of colour lanes that go through the divider.
	localparam int unsigned LANES = 3;

	// Restoring division steps done in each divider stage.
	localparam int unsigned DIV_STEPS_PER_STAGE = 2;

	// Output mode codes.
	localparam logic [2:0] MODE_RGBA = 3'd0;
	localparam logic [2:0] MODE_L    = 3'd1;
	localparam logic [2:0] MODE_A    = 3'd2;
	localparam logic [2:0] MODE_LA   = 3'd3;
	localparam logic [2:0] MODE_AL   = 3'd4;

	// Configuration register indexes.
	localparam logic [1:0] CFG_OUT_MODE    = 2'd0;
	localparam logic [1:0] CFG_UNPREMUL_EN = 2'd1;

	// Reset values of the configuration registers.
	localparam logic [2:0] OUT_MODE_RESET    = MODE_RGBA;
	localparam logic       UNPREMUL_EN_RESET = 1'b1;

	// Valid byte counts of an output pixel.
	localparam logic [2:0] BYTES_ONE  = 3'd1;
	localparam logic [2:0] BYTES_TWO  = 3'd2;
	localparam logic [2:0] BYTES_FOUR = 3'd4;

	// Input pixel.
	typedef struct packed {
		logic [7:0] in_byte0;
		logic [7:0] in_byte1;
		logic [7:0] in_byte2;
		logic [7:0] in_alpha;
		logic       last_pixel;
	} puc_in_t;

	// Output pixel.
	typedef struct packed {
		logic [31:0] out_word;
		logic [2:0]  out_bytes;
		logic        last_out;
	} puc_out_t;

	// First stage: the captured pixel with the settings it runs under.
	typedef struct packed {
		puc_in_t    pix;
		logic [2:0] mode;
		logic       en;
	} puc_s1_t;

	// Divider stages: partial remainder and dividend/quotient shifter per lane.
	typedef struct packed {
		logic [LANES-1:0][7:0] raw;
		logic [LANES-1:0][7:0] rem;
		logic [LANES-1:0][7:0] wrk;
		logic [LANES-1:0]      ovf;
		logic [7:0]            alpha;
		logic                  bypass;
		logic [2:0]            mode;
		logic                  last;
	} puc_work_t;

endpackage

`default_nettype wire

### rtl/pixel_unpremultiply_convert.sv
`default_nettype none

// Channel   Direction  Signals                       Contents
// input     in         in_valid, in_ready, in_data   premultiplied RGBA pixel, last flag
// output    out        out_valid, out_ready, out_data packed pixel, byte count, last flag
// config    in         cfg_valid, cfg_ready,         register index and write data
//                      cfg_index, cfg_data
//
// One pixel per clock is accepted and delivered while the output is not stalled;
// each transaction passes through capture, dividend setup, four stages of the
// restoring divider at two quotient bits each, and the output register.
// Reset clears every stage valid and sets mode RGBA with unpremultiply on.
// A stall at the output backs up stage by stage; empty stages still fill.
// The configuration port is always ready.

module pixel_unpremultiply_convert
	import puc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire puc_in_t    in_data,
	output logic            out_valid,
	input  wire logic       out_ready,
	output puc_out_t        out_data,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [2:0] cfg_data
);

	logic [2:0] out_mode_q;
	logic       unpremul_en_q;
	logic       valid_s2, ready_s3;
	logic       valid_s6, ready_s6;
	puc_work_t  work_s2, work_s6;

	assign cfg_ready = 1'b1;

	// Configuration registers; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_mode_q    <= OUT_MODE_RESET;
			unpremul_en_q <= UNPREMUL_EN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_OUT_MODE:    out_mode_q    <= cfg_data;
				CFG_UNPREMUL_EN: unpremul_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	puc_prep u_prep (
		.clk                  (clk),
		.arst_n               (arst_n),
		.in_valid             (in_valid),
		.in_ready             (in_ready),
		.in_data              (in_data),
		.out_mode             (out_mode_q),
		.unpremultiply_enable (unpremul_en_q),
		.valid_s2             (valid_s2),
		.ready_next           (ready_s3),
		.work_s2              (work_s2)
	);

	puc_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s2   (valid_s2),
		.ready_s3   (ready_s3),
		.work_s2    (work_s2),
		.valid_s6   (valid_s6),
		.ready_next (ready_s6),
		.work_s6    (work_s6)
	);

	puc_format u_format (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s6  (valid_s6),
		.ready_s6  (ready_s6),
		.work_s6   (work_s6),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

### rtl/puc_prep.sv
`default_nettype none

module puc_prep
	import puc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire puc_in_t    in_data,
	input  wire logic [2:0] out_mode,
	input  wire logic       unpremultiply_enable,
	output logic            valid_s2,
	input  wire logic       ready_next,
	output puc_work_t       work_s2
);

	logic                   valid_s1;
	puc_s1_t                pix_s1;
	logic                   ready_s1;
	logic                   ready_s2;
	logic [LANES-1:0][7:0]  ch;
	logic [LANES-1:0][15:0] num;
	puc_work_t              work_d;

	// A stage takes new data when it is empty or its contents move on.
	assign ready_s2 = !valid_s2 || ready_next;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	// Valid bits of both stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Stage 1 captures the pixel together with the current settings.
	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			pix_s1.pix  <= in_data;
			pix_s1.mode <= out_mode;
			pix_s1.en   <= unpremultiply_enable;
		end
	end

	assign ch = {pix_s1.pix.in_byte2, pix_s1.pix.in_byte1, pix_s1.pix.in_byte0};

	// Stage 2 forms the dividend c*255 + alpha/2 and checks whether the
	// quotient would exceed eight bits, in which case it clamps to 255.
	always_comb begin
		work_d.raw    = ch;
		work_d.alpha  = pix_s1.pix.in_alpha;
		work_d.bypass = !pix_s1.en || (pix_s1.pix.in_alpha == 8'h00);
		work_d.mode   = pix_s1.mode;
		work_d.last   = pix_s1.pix.last_pixel;
		for (int l = 0; l < LANES; l++) begin
			num[l] = {ch[l], 8'h00} - {8'h00, ch[l]} + {9'h000, pix_s1.pix.in_alpha[7:1]};
			work_d.ovf[l] = (num[l] >= {pix_s1.pix.in_alpha, 8'h00});
			work_d.rem[l] = num[l][15:8];
			work_d.wrk[l] = num[l][7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			work_s2 <= work_d;
		end
	end

endmodule

`default_nettype wire

### rtl/puc_div.sv
`default_nettype none

`include "pixel_unpremultiply_convert_macros.svh"

module puc_div
	import puc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      valid_s2,
	output logic           ready_s3,
	input  wire puc_work_t work_s2,
	output logic           valid_s6,
	input  wire logic      ready_next,
	output puc_work_t      work_s6
);

	logic      valid_s3, valid_s4, valid_s5;
	logic      ready_s4, ready_s5, ready_s6;
	puc_work_t work_s3, work_s4, work_s5;

	// Restoring division steps on all lanes. The partial remainder stays
	// below alpha, so it fits in eight bits; the quotient bits shift in at
	// the bottom of the dividend shifter as its upper bits are used up.
	function automatic puc_work_t div_steps(input puc_work_t w);
		puc_work_t  r;
		logic [8:0] t;
		r = w;
		for (int l = 0; l < LANES; l++) begin
			for (int k = 0; k < DIV_STEPS_PER_STAGE; k++) begin
				t = {r.rem[l], r.wrk[l][7]};
				if (t >= {1'b0, r.alpha}) begin
					r.rem[l] = 8'(t - {1'b0, r.alpha});
					r.wrk[l] = {r.wrk[l][6:0], 1'b1};
				end else begin
					r.rem[l] = t[7:0];
					r.wrk[l] = {r.wrk[l][6:0], 1'b0};
				end
			end
		end
		return r;
	endfunction

	// Ready chain through the divider stages.
	assign ready_s6 = !valid_s6 || ready_next;
	assign ready_s5 = !valid_s5 || ready_s6;
	assign ready_s4 = !valid_s4 || ready_s5;
	assign ready_s3 = !valid_s3 || ready_s4;

	// Valid bits move with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
			if (ready_s5) begin
				valid_s5 <= valid_s4;
			end
			if (ready_s6) begin
				valid_s6 <= valid_s5;
			end
		end
	end

	// Each stage resolves two quotient bits.
	always_ff @(posedge clk) begin
		if (valid_s2 && ready_s3) begin
			work_s3 <= div_steps(work_s2);
		end
		if (valid_s3 && ready_s4) begin
			work_s4 <= div_steps(work_s3);
		end
		if (valid_s4 && ready_s5) begin
			work_s5 <= div_steps(work_s4);
		end
		if (valid_s5 && ready_s6) begin
			work_s6 <= div_steps(work_s5);
		end
	end

	// A finished division leaves a remainder below the divisor on every lane
	// that neither clamps nor passes through.
	`PUC_ASSERT_NOW(a_rem_below_alpha, valid_s6 && !work_s6.bypass,
		(work_s6.ovf[0] || (work_s6.rem[0] < work_s6.alpha)) &&
		(work_s6.ovf[1] || (work_s6.rem[1] < work_s6.alpha)) &&
		(work_s6.ovf[2] || (work_s6.rem[2] < work_s6.alpha)),
		"divider remainder not below alpha")

	// A middle stage that cannot move keeps its transaction.
	`PUC_ASSERT_NEXT(a_s4_holds, valid_s4 && !ready_s5,
		valid_s4 && $stable(work_s4), "stage 4 lost or changed a stalled transaction")

endmodule

`default_nettype wire

### rtl/puc_format.sv
`default_nettype none

`include "pixel_unpremultiply_convert_macros.svh"

module puc_format
	import puc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      valid_s6,
	output logic           ready_s6,
	input  wire puc_work_t work_s6,
	output logic           out_valid,
	input  wire logic      out_ready,
	output puc_out_t       out_data
);

	logic                  out_valid_q;
	puc_out_t              out_data_s7;
	puc_out_t              pack_d;
	logic [LANES-1:0][7:0] val;

	assign ready_s6  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_s7;

	// Pick each colour byte: unchanged, clamped to 255, or the quotient.
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			if (work_s6.bypass) begin
				val[l] = work_s6.raw[l];
			end else if (work_s6.ovf[l]) begin
				val[l] = 8'hFF;
			end else begin
				val[l] = work_s6.wrk[l];
			end
		end
	end

	// Pack the output word for the selected mode; unknown modes act as RGBA.
	always_comb begin
		pack_d.last_out = work_s6.last;
		unique case (work_s6.mode)
			MODE_L: begin
				pack_d.out_word  = {24'h000000, work_s6.raw[2]};
				pack_d.out_bytes = BYTES_ONE;
			end
			MODE_A: begin
				pack_d.out_word  = {24'h000000, work_s6.alpha};
				pack_d.out_bytes = BYTES_ONE;
			end
			MODE_LA: begin
				pack_d.out_word  = {16'h0000, work_s6.alpha, val[2]};
				pack_d.out_bytes = BYTES_TWO;
			end
			MODE_AL: begin
				pack_d.out_word  = {16'h0000, val[2], work_s6.alpha};
				pack_d.out_bytes = BYTES_TWO;
			end
			default: begin
				pack_d.out_word  = {work_s6.alpha, val[2], val[1], val[0]};
				pack_d.out_bytes = BYTES_FOUR;
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready_s6) begin
			out_valid_q <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s6 && ready_s6) begin
			out_data_s7 <= pack_d;
		end
	end

	// Bytes beyond the valid count are zero.
	`PUC_ASSERT_NOW(a_one_byte_zero, out_valid_q && (out_data_s7.out_bytes == BYTES_ONE),
		out_data_s7.out_word[31:8] == 24'h000000, "single byte pixel has upper bytes set")
	`PUC_ASSERT_NOW(a_two_byte_zero, out_valid_q && (out_data_s7.out_bytes == BYTES_TWO),
		out_data_s7.out_word[31:16] == 16'h0000, "two byte pixel has upper bytes set")

endmodule

`default_nettype wire
